// File: rtl/fbpa_pkg.sv
// shared constants and types of the fixed block pool allocator
package fbpa_pkg;

    localparam int POOL_BLOCKS = 256;
    localparam int IDX_W       = 8;
    localparam int LINK_AW     = $clog2(POOL_BLOCKS);
    localparam int BYTES_W     = 13;
    localparam int OFFSET_W    = 20;
    localparam int COUNT_W     = 32;

    localparam logic [BYTES_W-1:0] BYTES_MIN = 13'd8;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USED_W = IDX_W + OFFSET_W + 3 * COUNT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 1;

    // one free list link: null mark and successor index
    typedef struct packed {
        logic             is_null;
        logic [IDX_W-1:0] idx;
    } t_link;

    // counter updates from the control path
    typedef struct packed {
        logic alloc_inc;
        logic free_inc;
    } t_count_ctl;

endpackage

// File: rtl/fbpa_link_mem.sv
// free list link memory with per-entry valid bits standing in for the reset image
module fbpa_link_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [fbpa_pkg::LINK_AW-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [fbpa_pkg::LINK_AW-1:0] i_wr_addr,
    input  fbpa_pkg::t_link              i_wr_link,
    output fbpa_pkg::t_link              o_rd_link
);
    import fbpa_pkg::*;

    t_link              r_mem [POOL_BLOCKS];
    logic [POOL_BLOCKS-1:0] r_valid;
    t_link              r_rd_data;
    logic               r_rd_valid;
    logic [LINK_AW-1:0] r_rd_addr;
    t_link              rst_link;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_addr <= i_rd_addr;
        end
    end

    // reset image: entry i links to i-1, entry 0 is the list end
    always_comb begin
        rst_link.is_null = (r_rd_addr == '0);
        rst_link.idx     = (r_rd_addr == '0) ? '0 : IDX_W'(r_rd_addr - 1'b1);
    end

    assign o_rd_link = r_rd_valid ? r_rd_data : rst_link;

endmodule

// File: rtl/fbpa_counters.sv
// wrapping allocation and free totals with the floored in-use figure
module fbpa_counters (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbpa_pkg::t_count_ctl         i_ctl,
    output logic [fbpa_pkg::COUNT_W-1:0] o_alloc_next,
    output logic [fbpa_pkg::COUNT_W-1:0] o_free_next,
    output logic [fbpa_pkg::COUNT_W-1:0] o_in_use_next
);
    import fbpa_pkg::*;

    logic [COUNT_W-1:0] r_alloc;
    logic [COUNT_W-1:0] r_free;
    logic [COUNT_W-1:0] n_alloc;
    logic [COUNT_W-1:0] n_free;

    assign n_alloc = r_alloc + COUNT_W'(i_ctl.alloc_inc);
    assign n_free  = r_free + COUNT_W'(i_ctl.free_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_free  <= '0;
        end else begin
            r_alloc <= n_alloc;
            r_free  <= n_free;
        end
    end

    assign o_alloc_next  = n_alloc;
    assign o_free_next   = n_free;
    assign o_in_use_next = (n_alloc > n_free) ? (n_alloc - n_free) : '0;

endmodule

// File: rtl/fixed_block_pool_allocator_top.sv
// top level of the fixed block pool allocator
//
// Hands out and takes back equal blocks of a pool of 256, kept as a LIFO
// linked free list whose links live in a 256 x 9 synchronous memory. After
// reset every block is free with the highest index at the head; there is no
// clearing pass, per-entry valid bits stand in for the initial links, so
// requests are taken from the first cycle after reset. A request is handled
// by a link memory read at the list head when it is taken, then by a step
// that picks the new head, writes the link of a returned block and loads the
// result register. The result register lets the next request enter while a
// result waits; a request that finishes while the previous result is still
// unclaimed holds in the execute state until the sink takes it. An allocate on
// an empty list and a return of a null block give a result with no state
// change. Double returns are not checked. The block size register is clamped
// to 8..4096 and should be written only while no request is in flight.
module fixed_block_pool_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // block size register
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::BYTES_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [fbpa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // block_index
    input  logic [fbpa_pkg::IN_USER_W-1:0]  i_s_axis_tuser,  // opcode, block_present
    // result channel
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // given_index, given_offset, alloc_total, free_total, blocks_in_use, zero pad
    output logic [fbpa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [fbpa_pkg::OUT_USER_W-1:0] o_m_axis_tuser   // granted
);
    import fbpa_pkg::*;

    localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(POOL_BLOCKS);
    localparam int PROD_W = IDX_W + BYTES_W;
    localparam int OUT_PAD = OUT_DATA_W - OUT_USED_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // captured request
    logic             r_op;
    logic             r_present;
    logic [IDX_W-1:0] r_idx;

    // list head and block size
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   n_head;
    logic               r_empty;
    logic               n_empty;
    logic [BYTES_W-1:0] r_block_bytes;
    logic [BYTES_W-1:0] cfg_clamped;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic       accept;
    logic       out_free;
    logic       finish;
    logic       alloc_ok;
    logic       free_ok;
    t_link      head_link;
    t_link      wr_link;
    t_count_ctl count_ctl;
    logic [COUNT_W-1:0] alloc_next;
    logic [COUNT_W-1:0] free_next;
    logic [COUNT_W-1:0] in_use_next;
    logic [PROD_W-1:0]  prod;
    logic [IDX_W-1:0]    given_index;
    logic [OFFSET_W-1:0] given_offset;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign finish   = (r_state == S_EXEC) && out_free;

    // block size register, clamped on write
    always_comb begin
        if (i_cfg_wdata < BYTES_MIN) begin
            cfg_clamped = BYTES_MIN;
        end else if (i_cfg_wdata > BYTES_MAX) begin
            cfg_clamped = BYTES_MAX;
        end else begin
            cfg_clamped = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BYTES_MIN;
        end else if (i_cfg_we) begin
            r_block_bytes <= cfg_clamped;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_s_axis_tuser[0];
            r_present <= i_s_axis_tuser[1];
            r_idx     <= i_s_axis_tdata[IDX_W-1:0];
        end
    end

    // what the captured request does; indexes outside the pool act as null
    assign alloc_ok = (r_op == OP_ALLOC) && !r_empty && ({1'b0, r_head} < IDX_LIMIT);
    assign free_ok  = (r_op == OP_FREE) && r_present && ({1'b0, r_idx} < IDX_LIMIT);

    // a returned block links to the old head, or ends the list if it was empty
    always_comb begin
        wr_link.is_null = r_empty;
        wr_link.idx     = r_empty ? '0 : r_head;
    end

    fbpa_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (LINK_AW'(r_head)),
        .i_wr_en   (finish && free_ok),
        .i_wr_addr (LINK_AW'(r_idx)),
        .i_wr_link (wr_link),
        .o_rd_link (head_link)
    );

    // head update: pop follows the head's link, push makes the block the head
    always_comb begin
        n_head  = r_head;
        n_empty = r_empty;
        priority if (alloc_ok) begin
            n_head  = head_link.is_null ? '0 : head_link.idx;
            n_empty = head_link.is_null;
        end else if (free_ok) begin
            n_head  = r_idx;
            n_empty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= IDX_W'(POOL_BLOCKS - 1);
            r_empty <= 1'b0;
        end else if (finish) begin
            r_head  <= n_head;
            r_empty <= n_empty;
        end
    end

    always_comb begin
        count_ctl.alloc_inc = finish && alloc_ok;
        count_ctl.free_inc  = finish && free_ok;
    end

    fbpa_counters u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (count_ctl),
        .o_alloc_next  (alloc_next),
        .o_free_next   (free_next),
        .o_in_use_next (in_use_next)
    );

    // byte offset of the granted block
    assign prod         = PROD_W'(r_head) * PROD_W'(r_block_bytes);
    assign given_index  = alloc_ok ? r_head : '0;
    assign given_offset = alloc_ok ? prod[OFFSET_W-1:0] : '0;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= {{OUT_PAD{1'b0}}, in_use_next, free_next, alloc_next,
                           given_offset, given_index};
            r_out_user <= OUT_USER_W'(alloc_ok);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// File: rtl/fbpa_checker.sv
// port-level checks of the fixed block pool allocator and their binding
module fbpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [fbpa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [fbpa_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import fbpa_pkg::*;

    localparam int GIVE_W  = IDX_W + OFFSET_W;

    logic s_accept;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("request taken while another is in flight");

    // a request whose link read is done and that finds room at the output gives a registered result
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept ##1 (!o_m_axis_tvalid || i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result missing after request");

    // no grant means zero index and offset
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[GIVE_W-1:0] == '0)
        else $error("index or offset set without a grant");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

// File: dv/fbpa_result_checker.sv
// result checker of the fixed block pool allocator: free list prediction and compare
module fbpa_result_checker
    import fbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BYTES_W-1:0]    i_cfg_wdata,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_DATA_W-1:0]  i_req_data,   // block_index
    input  logic [IN_USER_W-1:0]  i_req_user,   // opcode, block_present
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    // given_index, given_offset, alloc_total, free_total, blocks_in_use, zero pad
    input  logic [OUT_DATA_W-1:0] i_rsp_data,
    input  logic [OUT_USER_W-1:0] i_rsp_user,   // granted
    output int                    o_pending,
    output int                    o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFF_LSB   = IDX_W;
    localparam int ALLOC_LSB = OFF_LSB + OFFSET_W;
    localparam int FREE_LSB  = ALLOC_LSB + COUNT_W;
    localparam int USE_LSB   = FREE_LSB + COUNT_W;

    typedef struct packed {
        logic                granted;
        logic [IDX_W-1:0]    index;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  allocs;
        logic [COUNT_W-1:0]  frees;
        logic [COUNT_W-1:0]  in_use;
    } t_grant_reply;

    // mirrored free list
    logic [IDX_W-1:0]   succ [POOL_BLOCKS];
    logic               tail_mark [POOL_BLOCKS];
    logic [IDX_W-1:0]   head;
    logic               list_dry;
    logic [COUNT_W-1:0] grants;
    logic [COUNT_W-1:0] returns;
    logic [BYTES_W-1:0] blk_size;

    t_grant_reply owed_replies [$];

    function automatic logic [BYTES_W-1:0] clamp_size(input logic [BYTES_W-1:0] v);
        if (v < BYTES_MIN) return BYTES_MIN;
        if (v > BYTES_MAX) return BYTES_MAX;
        return v;
    endfunction

    function automatic t_grant_reply serve_request(input logic op, input logic present,
                                                   input logic [IDX_W-1:0] idx);
        t_grant_reply r;
        logic [31:0]  prod;
        r = '0;
        if (op == OP_ALLOC) begin
            if (!list_dry) begin
                r.granted = 1'b1;
                r.index   = head;
                prod      = 32'(head);
                prod      = prod * blk_size;
                r.offset  = prod[OFFSET_W-1:0];
                if (tail_mark[head]) begin
                    list_dry = 1'b1;
                    head     = '0;
                end else begin
                    head = succ[head];
                end
                grants = grants + 1'b1;
            end
        end else if (present && int'(idx) < POOL_BLOCKS) begin
            tail_mark[idx] = list_dry;
            succ[idx]      = list_dry ? '0 : head;
            head           = idx;
            list_dry       = 1'b0;
            returns        = returns + 1'b1;
        end
        r.allocs = grants;
        r.frees  = returns;
        r.in_use = (grants > returns) ? grants - returns : '0;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            if (o_errors < 10)
                $display("mismatch in %s: expected %0d, got %0d", what, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_grant_reply want;
        t_grant_reply got;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_BLOCKS; i++) begin
                succ[i]      = (i == 0) ? '0 : IDX_W'(i - 1);
                tail_mark[i] = (i == 0);
            end
            head     = IDX_W'(POOL_BLOCKS - 1);
            list_dry = 1'b0;
            grants   = '0;
            returns  = '0;
            blk_size = BYTES_MIN;
            owed_replies.delete();
        end else begin
            if (i_cfg_we)
                blk_size = clamp_size(i_cfg_wdata);
            if (i_req_valid && i_req_ready)
                owed_replies.push_back(serve_request(i_req_user[0], i_req_user[1],
                                                     i_req_data));
            if (i_rsp_valid && i_rsp_ready) begin
                got.granted = i_rsp_user[0];
                got.index   = i_rsp_data[IDX_W-1:0];
                got.offset  = i_rsp_data[ALLOC_LSB-1:OFF_LSB];
                got.allocs  = i_rsp_data[FREE_LSB-1:ALLOC_LSB];
                got.frees   = i_rsp_data[USE_LSB-1:FREE_LSB];
                got.in_use  = i_rsp_data[USE_LSB+COUNT_W-1:USE_LSB];
                if (owed_replies.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result: index %0d, allocs %0d",
                                 got.index, got.allocs);
                    o_errors++;
                end else begin
                    want = owed_replies.pop_front();
                    check_field("granted", COUNT_W'(want.granted), COUNT_W'(got.granted));
                    check_field("given_index", COUNT_W'(want.index), COUNT_W'(got.index));
                    check_field("given_offset", COUNT_W'(want.offset),
                                COUNT_W'(got.offset));
                    check_field("alloc_total", want.allocs, got.allocs);
                    check_field("free_total", want.frees, got.frees);
                    check_field("blocks_in_use", want.in_use, got.in_use);
                end
            end
        end
        o_pending = owed_replies.size();
    end

endmodule

// File: dv/tb_fixed_block_pool_allocator_top.sv
// testbench top of the fixed block pool allocator: stimulus, sink and verdict
module tb_fixed_block_pool_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fbpa_pkg::*;

    // sink behavior, drawn anew at random when the current mode's run ends
    typedef enum int {SINK_OPEN, SINK_BUSY, SINK_SLOW, SINK_TOGGLE} t_sink_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [BYTES_W-1:0]    i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // block_index
    logic [IN_USER_W-1:0]  i_s_axis_tuser;   // opcode, block_present
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // given_index, given_offset, alloc_total, free_total, blocks_in_use, zero pad
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;   // granted

    int               mismatches;
    int               owed;
    logic [IDX_W-1:0] held [$];   // blocks granted and not yet handed back
    int               burst_left;
    bit               hold_req;   // asks the sink for one long hold-off

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    fixed_block_pool_allocator_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    fbpa_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_ready (o_s_axis_tready),
        .i_req_data  (i_s_axis_tdata),
        .i_req_user  (i_s_axis_tuser),
        .i_rsp_valid (o_m_axis_tvalid),
        .i_rsp_ready (i_m_axis_tready),
        .i_rsp_data  (o_m_axis_tdata),
        .i_rsp_user  (o_m_axis_tuser),
        .o_pending   (owed),
        .o_errors    (mismatches)
    );

    // record every granted block so that returns can be well formed
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[0])
            held.push_back(o_m_axis_tdata[IDX_W-1:0]);
    end

    // one request, held until taken; bursts of random length, random gaps
    task automatic offer(input logic op, input logic present, input logic [IDX_W-1:0] idx);
        bit took;
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= {present, op};
        i_s_axis_tdata  <= idx;
        // ready is stable at the falling edge, so the next rising edge takes it
        do begin
            @(negedge i_clk);
            took = o_s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [IDX_W-1:0] take_held();
        int k;
        k         = $urandom_range(0, held.size() - 1);
        take_held = held[k];
        held.delete(k);
    endfunction

    // hand back a known block and drop it from the held list
    task automatic give_back(input logic [IDX_W-1:0] idx);
        for (int k = 0; k < held.size(); k++) begin
            if (held[k] == idx) begin
                held.delete(k);
                break;
            end
        end
        offer(OP_FREE, 1'b1, idx);
    endtask

    // sender pauses until every outstanding result has been taken
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (owed != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // block size write, only with the pool idle
    task automatic set_block_size(input logic [BYTES_W-1:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // mix weighted by alloc_pct; returns mostly of held blocks, some null returns
    task automatic mixed_item(input int alloc_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            offer(OP_FREE, 1'b0, IDX_W'($urandom_range(0, 255)));
        else if (roll < 6 + alloc_pct || held.size() == 0)
            offer(OP_ALLOC, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 255)));
        else
            offer(OP_FREE, 1'b1, take_held());
    endtask

    // result sink: random stall pattern plus one long hold-off on request
    initial begin
        t_sink_mode mode;
        int         mode_left;
        i_m_axis_tready = 1'b0;
        mode            = SINK_OPEN;
        mode_left       = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   i_m_axis_tready <= 1'b1;
                SINK_BUSY:   i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                SINK_SLOW:   i_m_axis_tready <= ($urandom_range(0, 9) < 3);
                default:     i_m_axis_tready <= ~i_m_axis_tready;
            endcase
        end
    end

    // stimulus and verdict
    initial begin
        logic [IDX_W-1:0] blk;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = BYTES_MIN;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        hold_req        = 1'b0;
        burst_left      = $urandom_range(1, 20);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset block size: top of the list, ignored present bit,
        // null returns at both index extremes, LIFO reuse of returned blocks
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b1, 8'd255);
        offer(OP_FREE, 1'b0, 8'd255);
        offer(OP_FREE, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b1, 8'hAA);
        settle();
        give_back(8'd255);
        give_back(8'd253);
        offer(OP_ALLOC, 1'b0, 8'h55);
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b1, 8'd255);
        settle();
        give_back(8'd254);
        give_back(8'd252);
        give_back(8'd255);
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b0, 8'd0);

        // largest blocks; drain the whole pool, long sink hold-off on the way
        set_block_size(13'd4096);
        for (int n = 0; n < 280; n++) begin
            if (n == 40)
                hold_req = 1'b1;
            mixed_item(92);
        end
        settle();
        while (held.size() < POOL_BLOCKS)
            offer(OP_ALLOC, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 255)));
        // empty list: allocates fail, a return onto it becomes the last link
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b1, 8'd255);
        settle();
        offer(OP_FREE, 1'b1, take_held());
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b0, 8'd0);
        settle();
        offer(OP_FREE, 1'b1, take_held());
        offer(OP_FREE, 1'b1, take_held());
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b0, 8'd0);

        // mixed traffic over clamped, extreme and random block sizes
        for (int p = 1; p <= 5; p++) begin
            case (p)
                1:       set_block_size(13'd0);
                2:       set_block_size(13'h1FFF);
                3:       set_block_size(BYTES_W'($urandom_range(8, 4096)));
                4:       set_block_size(13'd7);
                default: set_block_size(BYTES_W'($urandom_range(0, 8191)));
            endcase
            settle();
            for (int n = 0; n < 55; n++)
                mixed_item($urandom_range(25, 75));
        end

        // noise last: double return forms a loop, then anything goes
        set_block_size(BYTES_W'($urandom_range(8, 4096)));
        settle();
        blk = (held.size() > 0) ? take_held() : 8'd37;
        offer(OP_FREE, 1'b1, blk);
        offer(OP_FREE, 1'b1, blk);
        offer(OP_ALLOC, 1'b0, 8'd0);
        offer(OP_ALLOC, 1'b0, 8'd0);
        for (int n = 0; n < 60; n++)
            offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  IDX_W'($urandom_range(0, 255)));

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
